>>> sv/clc_pkg.sv
`timescale 1ns / 1ps

package clc_pkg;

  // Field widths
  localparam int CARD_W      = 54;
  localparam int COUNT_W     = 5;
  localparam int CLASS_W     = 2;

  // A 54-bit value has at most 17 decimal digits
  localparam int BCD_DIGITS  = 17;
  localparam int BCD_W       = 4 * BCD_DIGITS;

  // Shift-and-add-3 steps folded into each conversion stage
  localparam int STEPS_PER_STAGE = 6;
  localparam int BCD_STAGES      = CARD_W / STEPS_PER_STAGE;

  // Luhn partial sums: digits grouped five to a group
  localparam int GROUP_LEN   = 5;
  localparam int GROUPS      = (BCD_DIGITS + GROUP_LEN - 1) / GROUP_LEN;
  localparam int PSUM_W      = 6;
  localparam int SUM_W       = 8;

  // Length limits
  localparam int MAX_DIGITS  = 16;
  localparam int FIELD_LIMIT = 16;
  localparam int LEN_SHORT   = 13;
  localparam int LEN_MID     = 15;
  localparam int LEN_LONG    = 16;

  // Conversion to the luhn stage adds three more registers
  localparam int PIPE_LAT    = BCD_STAGES + 3;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_PFX4    = 2'd1,
    CLASS_PFX5X   = 2'd2,
    CLASS_PFX3X   = 2'd3
  } card_class_t;

  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [CARD_W-1:0] bin;
  } conv_t;

endpackage

>>> sv/card_number_luhn_classifier_core.sv
`timescale 1ns / 1ps

// Card number Luhn classifier. Raise start for one cycle with a binary card
// number on card_number; busy is never raised, so a new request can be
// given every cycle. Each request yields one result, shown for one cycle
// with done high: card_class, checksum_ok and digit_count. The receiver
// cannot stall the result, so it must capture it in that cycle. The
// pipeline is nine binary-to-BCD stages (six shift-and-add-3 steps each,
// 54 bits in all) followed by three stages for digit count and Luhn
// partial sums, the total sum with the leading digits, and the mod-10
// test with the class. Results come out in request order; the block keeps
// no state between requests.
module card_number_luhn_classifier_core import clc_pkg::*; #(
  parameter int MAX_DIGITS = clc_pkg::MAX_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CARD_W-1:0]  card_number,
  output logic               done,
  output logic [CLASS_W-1:0] card_class,
  output logic               checksum_ok,
  output logic [COUNT_W-1:0] digit_count
);

  // Fully pipelined: never holds a request off
  assign busy = 1'b0;

  // Conversion chain; slot 0 is the request itself
  logic  conv_valid [BCD_STAGES+1];
  conv_t conv       [BCD_STAGES+1];

  assign conv_valid[0] = start & ~busy;
  assign conv[0]       = '{bcd: '0, bin: card_number};

  for (genvar g = 0; g < BCD_STAGES; g++) begin : g_bcd
    clc_bcd_stage #(
      .STEPS (STEPS_PER_STAGE)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (conv_valid[g]),
      .in_conv   (conv[g]),
      .out_valid (conv_valid[g+1]),
      .out_conv  (conv[g+1])
    );
  end

  // Digit analysis and classification
  card_class_t eval_class;

  clc_luhn_eval #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (conv_valid[BCD_STAGES]),
    .in_bcd    (conv[BCD_STAGES].bcd),
    .out_valid (done),
    .out_class (eval_class),
    .out_ok    (checksum_ok),
    .out_count (digit_count)
  );

  assign card_class = eval_class;

endmodule

>>> sv/clc_bcd_stage.sv
`timescale 1ns / 1ps

// STEPS double-dabble steps, registered.
module clc_bcd_stage import clc_pkg::*; #(
  parameter int STEPS = STEPS_PER_STAGE
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  conv_t in_conv,
  output logic  out_valid,
  output conv_t out_conv
);

  conv_t work;
  conv_t conv_next;

  always_comb begin
    work = in_conv;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (work.bcd[4*d +: 4] >= 4'd5) begin
          work.bcd[4*d +: 4] = work.bcd[4*d +: 4] + 4'd3;
        end
      end
      work = conv_t'({work.bcd, work.bin} << 1);
    end
    conv_next = work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_conv <= conv_next;
  end

endmodule

>>> sv/clc_luhn_eval.sv
`timescale 1ns / 1ps

// Digit count, Luhn sum and classification over three registered stages.
module clc_luhn_eval import clc_pkg::*; #(
  parameter int MAX_DIGITS = clc_pkg::MAX_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [BCD_W-1:0]   in_bcd,
  output logic               out_valid,
  output card_class_t        out_class,
  output logic               out_ok,
  output logic [COUNT_W-1:0] out_count
);

  // stage 1: count, partial sums
  logic                     s1_valid;
  logic [BCD_W-1:0]         s1_bcd;
  logic [COUNT_W-1:0]       s1_count;
  logic [GROUPS*PSUM_W-1:0] s1_psum;
  logic [COUNT_W-1:0]       count_next;
  logic [GROUPS*PSUM_W-1:0] psum_next;
  logic [3:0]               dig;
  logic [4:0]               dbl;
  logic [PSUM_W-1:0]        acc;

  always_comb begin
    count_next = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (in_bcd[4*i +: 4] != 4'd0) begin
        count_next = COUNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    psum_next = '0;
    dig       = '0;
    dbl       = '0;
    acc       = '0;
    for (int g = 0; g < GROUPS; g++) begin
      acc = '0;
      for (int j = 0; j < GROUP_LEN; j++) begin
        if (g * GROUP_LEN + j < BCD_DIGITS) begin
          dig = in_bcd[4*(g*GROUP_LEN + j) +: 4];
          if (((g * GROUP_LEN + j) % 2) == 1) begin
            dbl = {dig, 1'b0};
            if (dbl >= 5'd10) begin
              dbl = dbl - 5'd9;
            end
          end else begin
            dbl = {1'b0, dig};
          end
          acc = acc + PSUM_W'(dbl);
        end
      end
      psum_next[g*PSUM_W +: PSUM_W] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_bcd   <= in_bcd;
    s1_count <= count_next;
    s1_psum  <= psum_next;
  end

  // stage 2: total, leading digits
  logic               s2_valid;
  logic [COUNT_W-1:0] s2_count;
  logic [SUM_W-1:0]   s2_sum;
  logic [3:0]         s2_top;
  logic [3:0]         s2_second;
  logic [SUM_W-1:0]   sum_next;
  logic [3:0]         top_next;
  logic [3:0]         second_next;

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_next = sum_next + SUM_W'(s1_psum[g*PSUM_W +: PSUM_W]);
    end
  end

  always_comb begin
    top_next    = '0;
    second_next = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (s1_count == COUNT_W'(i + 1)) begin
        top_next = s1_bcd[4*i +: 4];
      end
      if (s1_count == COUNT_W'(i + 2)) begin
        second_next = s1_bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_count  <= s1_count;
    s2_sum    <= sum_next;
    s2_top    <= top_next;
    s2_second <= second_next;
  end

  // stage 3: mod-10 test, class
  logic        ok_next;
  card_class_t class_next;
  logic        len_fits;

  always_comb begin
    ok_next = 1'b0;
    for (int k = 0; k < (1 << SUM_W) / 10; k++) begin
      if (s2_sum == SUM_W'(k * 10)) begin
        ok_next = 1'b1;
      end
    end
  end

  always_comb begin
    len_fits   = (s2_count <= COUNT_W'(MAX_DIGITS)) &&
                 (s2_count <= COUNT_W'(FIELD_LIMIT));
    class_next = CLASS_NONE;
    if (len_fits && ok_next) begin
      if (s2_count == COUNT_W'(LEN_SHORT) && s2_top == 4'd4) begin
        class_next = CLASS_PFX4;
      end else if (s2_count == COUNT_W'(LEN_LONG) && s2_top == 4'd4) begin
        class_next = CLASS_PFX4;
      end else if (s2_count == COUNT_W'(LEN_LONG) && s2_top == 4'd5 &&
                   s2_second >= 4'd1 && s2_second <= 4'd5) begin
        class_next = CLASS_PFX5X;
      end else if (s2_count == COUNT_W'(LEN_MID) && s2_top == 4'd3 &&
                   (s2_second == 4'd4 || s2_second == 4'd7)) begin
        class_next = CLASS_PFX3X;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_class <= class_next;
    out_ok    <= ok_next;
    out_count <= s2_count;
  end

endmodule

>>> sv/clc_checker.sv
`timescale 1ns / 1ps

module clc_checker import clc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [CARD_W-1:0]  card_number,
  input logic               done,
  input logic [CLASS_W-1:0] card_class,
  input logic               checksum_ok,
  input logic [COUNT_W-1:0] digit_count
);

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_LAT))
    else $error("result without matching request");

  // a nonzero class needs a passing checksum
  a_class_ok: assert property (@(posedge clk) disable iff (rst)
    (done && card_class != CLASS_NONE) |-> checksum_ok)
    else $error("class given on failed checksum");

  a_len_pfx4: assert property (@(posedge clk) disable iff (rst)
    (done && card_class == CLASS_PFX4) |->
      (digit_count == COUNT_W'(LEN_SHORT) || digit_count == COUNT_W'(LEN_LONG)))
    else $error("prefix-4 class with wrong length");

  a_len_other: assert property (@(posedge clk) disable iff (rst)
    done |-> ((card_class != CLASS_PFX5X || digit_count == COUNT_W'(LEN_LONG)) &&
              (card_class != CLASS_PFX3X || digit_count == COUNT_W'(LEN_MID))))
    else $error("class and length disagree");

endmodule

bind card_number_luhn_classifier_core clc_checker u_clc_checker (.*);
